>>> src/cosine_similarity_distance_unit_assert.svh
// assertion macros for the cosine similarity unit
`ifndef COSINE_SIMILARITY_DISTANCE_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_DISTANCE_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/csd_pkg.sv
// package with types and constants of the cosine similarity unit
`default_nettype none
package csd_pkg;
  localparam int unsigned DotW = 42;
  localparam int unsigned SqW = 41;
  localparam logic [15:0] OneQ14 = 16'd16384;

  // request handed from front to back
  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [SqW-1:0] lsq;
    logic [SqW-1:0] rsq;
  } csd_req_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQL  = 7'b0000010,
    ST_SQR  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } csd_state_t;
endpackage
`default_nettype wire

>>> src/csd_in_if.sv
// input channel interface
`default_nettype none
interface csd_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_element;
  logic signed [15:0] right_element;
  logic last;
  modport source(output valid, left_element, right_element, last, input ready);
  modport sink(input valid, left_element, right_element, last, output ready);
endinterface
`default_nettype wire

>>> src/csd_out_if.sv
// result channel interface
`default_nettype none
interface csd_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] similarity;
  logic [15:0] distance;
  logic tolerance_used;
  modport source(output valid, similarity, distance, tolerance_used, input ready);
  modport sink(input valid, similarity, distance, tolerance_used, output ready);
endinterface
`default_nettype wire

>>> src/csd_front.sv
// front end: accumulates sums per element and hands finished vectors to the queue
`default_nettype none
module csd_front import csd_pkg::*; #(
  parameter int unsigned VectorLengthMax = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [15:0] in_left_element,
  input  wire logic signed [15:0] in_right_element,
  input  wire logic in_last,
  output logic req_valid,
  input  wire logic req_ready,
  output csd_req_t req
);
  localparam logic [DotW+1:0] Limit = (DotW+2)'(VectorLengthMax) << 30;

  logic signed [DotW-1:0] dot_r, dot_nxt;
  logic [SqW-1:0] lsq_r, lsq_nxt, rsq_r, rsq_nxt;
  logic signed [31:0] pab, paa, pbb;
  logic signed [DotW+1:0] dsum, lsum, rsum;
  logic fire;

  // hold off while a finished vector cannot enter the queue
  assign in_ready = req_ready;
  assign fire = in_valid && in_ready;

  assign pab = in_left_element * in_right_element;
  assign paa = in_left_element * in_left_element;
  assign pbb = in_right_element * in_right_element;

  // saturating sums
  always_comb begin
    dsum = (DotW+2)'(dot_r) + (DotW+2)'(pab);
    lsum = (DotW+2)'({1'b0, lsq_r}) + (DotW+2)'(paa);
    rsum = (DotW+2)'({1'b0, rsq_r}) + (DotW+2)'(pbb);
    if (dsum > $signed(Limit)) dsum = $signed(Limit);
    else if (dsum < -$signed(Limit)) dsum = -$signed(Limit);
    if (lsum > $signed(Limit)) lsum = $signed(Limit);
    if (rsum > $signed(Limit)) rsum = $signed(Limit);
    dot_nxt = dot_r;
    lsq_nxt = lsq_r;
    rsq_nxt = rsq_r;
    if (fire) begin
      dot_nxt = in_last ? '0 : dsum[DotW-1:0];
      lsq_nxt = in_last ? '0 : lsum[SqW-1:0];
      rsq_nxt = in_last ? '0 : rsum[SqW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      lsq_r <= '0;
      rsq_r <= '0;
    end else begin
      dot_r <= dot_nxt;
      lsq_r <= lsq_nxt;
      rsq_r <= rsq_nxt;
    end
  end

  assign req_valid = fire && in_last;
  assign req.dot = dsum[DotW-1:0];
  assign req.lsq = lsum[SqW-1:0];
  assign req.rsq = rsum[SqW-1:0];
endmodule
`default_nettype wire

>>> src/csd_queue.sv
// two-entry queue between front and back
`default_nettype none
module csd_queue import csd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic wr_ready,
  input  wire csd_req_t wr_data,
  output logic rd_valid,
  input  wire logic rd_ready,
  output csd_req_t rd_data
);
  csd_req_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

>>> src/csd_back.sv
// back end: square roots, norm product, rounded divide and result register
`default_nettype none
module csd_back import csd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [31:0] tolerance,
  input  wire logic req_valid,
  output logic req_ready,
  input  wire csd_req_t req,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [15:0] out_similarity,
  output logic [15:0] out_distance,
  output logic out_tolerance_used
);
  `include "cosine_similarity_distance_unit_assert.svh"

  csd_state_t st_r, st_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [31:0] nl_r, nl_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [63:0] div_r, div_nxt;
  logic [56:0] num_r, num_nxt;
  logic [56:0] quo_r, quo_nxt;
  logic [57:0] drem_r, drem_nxt;
  logic neg_r, neg_nxt, used_r, used_nxt;
  logic [SqW-1:0] rsq_r, rsq_nxt;
  logic signed [DotW-1:0] dot_r, dot_nxt;
  logic [15:0] sim_r, sim_nxt;
  logic [1:0] mstep_r, mstep_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [57:0] dtrial;
  logic [33:0] sq_try;
  logic [15:0] pp_a, pp_b;
  logic [31:0] pp;
  logic [41:0] mag;
  logic [56:0] q_sat;

  // restoring square root, one result bit per cycle
  always_comb begin
    sq_try = {root_r, 2'b01};
  end

  // 16x16 partial products of the 32x32 norm product, selected by mstep_r
  assign pp_a = mstep_r[0] ? nl_r[31:16] : nl_r[15:0];
  assign pp_b = mstep_r[1] ? root_r[31:16] : root_r[15:0];
  assign pp = pp_a * pp_b;
  assign mag = dot_r[DotW-1] ? 42'(-dot_r) : 42'(dot_r);
  assign dtrial = {drem_r[56:0], num_r[56]};

  always_comb begin
    logic [33:0] r2;
    logic [63:0] shifted;
    st_nxt = st_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    nl_nxt = nl_r;
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    drem_nxt = drem_r;
    neg_nxt = neg_r;
    used_nxt = used_r;
    rsq_nxt = rsq_r;
    dot_nxt = dot_r;
    sim_nxt = sim_r;
    mstep_nxt = mstep_r;
    prod_nxt = prod_r;
    r2 = '0;
    shifted = '0;
    q_sat = '0;
    case (st_r)
      ST_IDLE: begin
        if (req_valid) begin
          dot_nxt = req.dot;
          rsq_nxt = req.rsq;
          rem_nxt = 64'(req.lsq) << 22;
          root_nxt = '0;
          div_nxt = '0;
          cnt_nxt = 6'd31;
          st_nxt = ST_SQL;
        end
      end
      ST_SQL, ST_SQR: begin
        // radicand bits enter two at a time from the top
        shifted = {rem_r[61:0], 2'b00};
        // partial remainder held in div_r, radicand in rem_r
        r2 = {div_r[31:0], rem_r[63:62]};
        if (r2 >= sq_try) begin
          div_nxt = 64'(r2 - sq_try);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          div_nxt = 64'(r2);
          root_nxt = {root_r[30:0], 1'b0};
        end
        rem_nxt = shifted;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          div_nxt = '0;
          if (st_r == ST_SQL) begin
            nl_nxt = root_nxt;
            root_nxt = '0;
            rem_nxt = 64'(rsq_r) << 22;
            cnt_nxt = 6'd31;
            st_nxt = ST_SQR;
          end else begin
            mstep_nxt = 2'd0;
            prod_nxt = '0;
            st_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt = prod_r + (64'(pp) << ((6'(mstep_r[0]) + 6'(mstep_r[1])) * 6'd16));
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          used_nxt = 64'(tolerance) > (prod_nxt >> 22);
          div_nxt = used_nxt ? 64'(tolerance) : (prod_nxt >> 22);
          neg_nxt = dot_r[DotW-1];
          num_nxt = (57'(mag) << 14) + 57'((used_nxt ? 64'(tolerance) : (prod_nxt >> 22)) >> 1);
          quo_nxt = '0;
          drem_nxt = '0;
          cnt_nxt = 6'd56;
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if ({6'd0, dtrial} >= div_r) begin
          drem_nxt = 58'({6'd0, dtrial} - div_r);
          quo_nxt = {quo_r[55:0], 1'b1};
        end else begin
          drem_nxt = dtrial;
          quo_nxt = {quo_r[55:0], 1'b0};
        end
        num_nxt = {num_r[55:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        q_sat = (div_r == 64'd0) ? 57'd0 :
                (quo_r > 57'(OneQ14)) ? 57'(OneQ14) : quo_r;
        sim_nxt = neg_r ? 16'(-q_sat[15:0]) : q_sat[15:0];
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    nl_r <= nl_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    drem_r <= drem_nxt;
    neg_r <= neg_nxt;
    used_r <= used_nxt;
    rsq_r <= rsq_nxt;
    dot_r <= dot_nxt;
    sim_r <= sim_nxt;
    mstep_r <= mstep_nxt;
    prod_r <= prod_nxt;
  end

  assign req_ready = st_r == ST_IDLE;
  assign out_valid = st_r == ST_OUT;
  assign out_similarity = sim_r;
  assign out_distance = OneQ14 - sim_r;
  assign out_tolerance_used = used_r;

  // checks
  `CSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_similarity),
    "result changed while stalled")
  `CSD_ASSERT_IMP(a_sim_range, out_valid,
    ($signed(out_similarity) <= 16'sd16384) && ($signed(out_similarity) >= -16'sd16384),
    "similarity out of range")
  `CSD_ASSERT_NXT(a_take, req_valid && req_ready, st_r == ST_SQL, "request not taken")
endmodule
`default_nettype wire

>>> src/cosine_similarity_distance_unit.sv
// top level of the cosine similarity and distance unit
`default_nettype none
// Streams one element pair per cycle into saturating sums; on the pair marked
// last the sums go through a two-entry queue to the back end. The back end
// works on one vector at a time: it raises the result after two restoring
// square roots of 32 result bits each, a norm product from four 16x16 partial
// products, a restoring divide of 57 quotient bits and a saturation and sign
// step, and returns to idle to take the next vector once the result is
// accepted. Element pairs of the next vector keep streaming at one per cycle
// while the back end works, until the queue is full; then all input stalls.
module cosine_similarity_distance_unit import csd_pkg::*; #(
  parameter int unsigned VECTOR_LENGTH_MAX = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  csd_in_if.sink in_ch,
  csd_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [31:0] cfg_wdata
);
  logic [31:0] tol_r;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  csd_req_t fq_req, qb_req;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= 32'd1024;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  csd_front #(.VectorLengthMax(VECTOR_LENGTH_MAX)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_left_element(in_ch.left_element), .in_right_element(in_ch.right_element),
    .in_last(in_ch.last),
    .req_valid(fq_valid), .req_ready(fq_ready), .req(fq_req)
  );

  csd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_req),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_req)
  );

  csd_back u_back (
    .clk, .rst_n, .tolerance(tol_r),
    .req_valid(qb_valid), .req_ready(qb_ready), .req(qb_req),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_similarity(out_ch.similarity), .out_distance(out_ch.distance),
    .out_tolerance_used(out_ch.tolerance_used)
  );
endmodule
`default_nettype wire

>>> verif/csd_tb_if.sv
// testbench-side interfaces are those of the block; this file holds no extra logic
`default_nettype none
package csd_tb_pkg;
  localparam int unsigned LatencyCycles = 200;
endpackage
`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench of the cosine similarity and distance unit
`default_nettype none
module testbench;
  import csd_pkg::*;
  import csd_tb_pkg::*;

  localparam longint SumLimit = 64'd1024 << 30;
  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  csd_in_if in_ch();
  csd_out_if out_ch();

  cosine_similarity_distance_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic signed [15:0] similarity;
    logic [15:0] distance;
    logic tolerance_used;
  } score_t;

  // predictor state
  logic [31:0] tol_reg;
  longint dot_acc, lsq_acc, rsq_acc;
  score_t score_queue[$];
  int errors = 0;
  int watchdog = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // accumulate one pair and predict the score on a last pair
  task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
    longint unsigned nl, nr, prod, divisor, mag, q;
    longint sim;
    logic used;
    score_t s;
    dot_acc = clip(dot_acc + longint'(a) * longint'(b), -SumLimit, SumLimit);
    lsq_acc = clip(lsq_acc + longint'(a) * longint'(a), 0, SumLimit);
    rsq_acc = clip(rsq_acc + longint'(b) * longint'(b), 0, SumLimit);
    if (lst) begin
      nl = int_sqrt(longint'(lsq_acc) << 22);
      nr = int_sqrt(longint'(rsq_acc) << 22);
      prod = (nl * nr) >> 22;
      used = {32'd0, tol_reg} > prod;
      divisor = used ? {32'd0, tol_reg} : prod;
      if (divisor == 0) begin
        sim = 0;
      end else begin
        mag = dot_acc < 0 ? -dot_acc : dot_acc;
        q = ((mag << 14) + divisor / 2) / divisor;
        if (q > 16384) q = 16384;
        sim = dot_acc < 0 ? -longint'(q) : longint'(q);
      end
      s.similarity = sim[15:0];
      s.distance = 16'(16384 - sim);
      s.tolerance_used = used;
      score_queue.push_back(s);
      dot_acc = 0;
      lsq_acc = 0;
      rsq_acc = 0;
    end
  endtask

  // send one request and wait for its acceptance
  // valid stays high after acceptance; the next call replaces the pair or drops valid, and drain drops it
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_element <= a;
    in_ch.right_element <= b;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pair(a, b, lst);
  endtask

  // wait for all scores, then let the back end drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (score_queue.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_reg = v;
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    score_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.similarity, out_ch.distance, out_ch.tolerance_used};
        if (score_queue.size() == 0) begin
          $error("unexpected score sim=%0d", got.similarity);
          errors++;
        end else begin
          want = score_queue.pop_front();
          if (got.similarity !== want.similarity) begin
            $error("similarity exp %0d got %0d", want.similarity, got.similarity);
            errors++;
          end
          if (got.distance !== want.distance) begin
            $error("distance exp %0d got %0d", want.distance, got.distance);
            errors++;
          end
          if (got.tolerance_used !== want.tolerance_used) begin
            $error("tolerance_used exp %0b got %0b", want.tolerance_used, got.tolerance_used);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog over cycles with no handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
    end
    if (watchdog >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sh7fff, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd100, -16'sd200, 1'b0);
    send_pair(16'sd300, 16'sd50, 1'b0);
    send_pair(-16'sd7, 16'sd9, 1'b1);
    send_pair(16'sd0, 16'sd1234, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b1);
  endtask

  // zero divisor with tolerance zero, then an all-ones tolerance
  task automatic test_zero_divisor();
    write_tolerance(32'd0);
    send_pair(16'sd0, 16'sd500, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd3, 16'sd3, 1'b1);
    write_tolerance(32'hffff_ffff);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(-16'sd32768, 16'sh7fff, 1'b1);
  endtask

  // overlong vector drives the dot sum and both square sums into saturation
  task automatic test_saturation();
    write_tolerance(32'd1024);
    for (int i = 0; i < 1025; i++) send_pair(-16'sd32768, 16'sh7fff, i == 1024);
  endtask

  task automatic test_random(int n_items, logic [31:0] tol);
    int len, sent, mode;
    logic signed [15:0] a, b;
    write_tolerance(tol);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
      mode = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        a = 16'($urandom);
        b = (mode == 0) ? a : (mode == 1) ? -a : 16'($urandom);
        if (mode == 2) begin
          a = $signed(16'($urandom_range(15))) - 16'sd8;
          b = $signed(16'($urandom_range(15))) - 16'sd8;
        end
        send_pair(a, b, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_element = '0;
    in_ch.right_element = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b1;
    tol_reg = 32'd1024;
    dot_acc = 0;
    lsq_acc = 0;
    rsq_acc = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_divisor();
    test_saturation();
    test_random(30, 32'd0);
    send_idle_pct = 81;
    test_random(30, 32'd1024);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    test_random(30, 32'h4000_0000);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    test_random(30, $urandom);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
